// ===== src/wg_pkg.sv =====
// Shared types, codes and constants for the wave table generator.
`default_nettype none

package wg_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEF_TABLE_LEN   = 256;
   localparam int DEF_TABLE_COUNT = 8;

   // Width of the sample index field of an input item.
   localparam int SAMPLE_INDEX_W = 8;

   // Sample limits and the starting value of the saw and triangle ramps.
   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
   localparam logic [15:0]        RAMP_START = 16'h8000;

   // Fixed point constants for the sine series (Q2.30).
   localparam longint unsigned PIHALF_Q30   = 64'd1686629713;
   localparam longint unsigned ONE_Q30      = 64'd1 << 30;
   localparam int              SERIES_TERMS = 10;

   // Function codes carried by an input item.
   localparam logic [2:0] FUNC_SINE     = 3'd0;
   localparam logic [2:0] FUNC_SQUARE   = 3'd1;
   localparam logic [2:0] FUNC_SAW      = 3'd2;
   localparam logic [2:0] FUNC_TRIANGLE = 3'd3;
   localparam logic [2:0] FUNC_CLEAR    = 3'd4;
   localparam logic [2:0] FUNC_ADD      = 3'd5;
   localparam logic [2:0] FUNC_READ     = 3'd6;

   // One input item.
   typedef struct packed {
      logic [2:0]                func;
      logic [2:0]                wave_id;
      logic [8:0]                harmonic;
      logic [7:0]                trim;
      logic [SAMPLE_INDEX_W-1:0] sample_index;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [15:0] sample;
      logic               is_read;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the accepted item
      logic step;     // handle one table entry and advance
      logic read;     // read one sample
      logic publish;  // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk;     // item walks the whole table
      logic read;     // item reads one sample
      logic last;     // the entry being handled is the last one
   } status_type;

endpackage

`default_nettype wire

// ===== src/wavetable_generator_unit.sv =====
// Top level of the wave table generator.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_stall    wg_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall    wg_pkg::rsp_type
//
// A fill or harmonic add item passes through states decide, run and finish:
// the table is walked one entry per cycle through the single memory write
// port. Read item: decide, read, finish; a no-op item: decide, finish.
// Reset is synchronous and clears only control state; the tables are
// undefined until filled. A new item is taken while a result waits under
// rsp_stall; its result waits in turn until the output register is free.
`default_nettype none

module wavetable_generator_unit #(
   parameter int TABLE_LEN   = wg_pkg::DEF_TABLE_LEN,
   parameter int TABLE_COUNT = wg_pkg::DEF_TABLE_COUNT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire wg_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output wg_pkg::rsp_type      rsp_data
);
   import wg_pkg::*;

   cmd_type    cmd;
   status_type st;

   // Sequencer.
   wg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .st        (st)
   );

   // Tables and arithmetic.
   wg_datapath #(
      .TABLE_LEN   (TABLE_LEN),
      .TABLE_COUNT (TABLE_COUNT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .st       (st),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/wg_sine_rom.sv =====
// Constant reference sine table with a registered read port.
`default_nettype none

module wg_sine_rom #(
   parameter int TABLE_LEN = 256
) (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(TABLE_LEN)-1:0] rd_addr,
   output logic signed [15:0]                rd_data_ff
);
   import wg_pkg::*;

   // One entry: sin(2*pi*pos/TABLE_LEN)*32767 by a truncated Taylor series.
   function automatic logic signed [15:0] sine_entry(input int unsigned pos);
      longint unsigned quad;
      longint unsigned rem;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned prod;
      longint unsigned mag;
      longint          sum;
      logic            sin_mode;
      quad     = (64'(pos) * 64'd4) / TABLE_LEN;
      rem      = (64'(pos) * 64'd4) % TABLE_LEN;
      x        = (rem * PIHALF_Q30) / TABLE_LEN;
      x2       = (x * x) >> 30;
      sin_mode = (quad[0] == 1'b0);
      term     = sin_mode ? x : ONE_Q30;
      sum      = longint'(term);
      for (int k = 0; k < SERIES_TERMS; k++) begin
         prod = (term * x2) >> 30;
         unique case (k)
            0:       term = sin_mode ? prod / 6   : prod / 2;
            1:       term = sin_mode ? prod / 20  : prod / 12;
            2:       term = sin_mode ? prod / 42  : prod / 30;
            3:       term = sin_mode ? prod / 72  : prod / 56;
            4:       term = sin_mode ? prod / 110 : prod / 90;
            5:       term = sin_mode ? prod / 156 : prod / 132;
            6:       term = sin_mode ? prod / 210 : prod / 182;
            7:       term = sin_mode ? prod / 272 : prod / 240;
            8:       term = sin_mode ? prod / 342 : prod / 306;
            9:       term = sin_mode ? prod / 420 : prod / 380;
            default: term = 64'd0;
         endcase
         if (k[0]) begin
            sum = sum + longint'(term);
         end else begin
            sum = sum - longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(ONE_Q30)) begin
         sum = longint'(ONE_Q30);
      end
      mag = (64'(sum) * 64'd32767) >> 30;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return (quad >= 64'd2) ? 16'(-longint'(mag)) : 16'(mag);
   endfunction

   logic signed [15:0] rom [TABLE_LEN];

   // The table contents are fixed at elaboration.
   for (genvar g = 0; g < TABLE_LEN; g++) begin : g_rom
      assign rom[g] = sine_entry(g);
   end

   // Registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/wg_datapath.sv =====
// Wave table memory, entry walker and sample arithmetic.
`default_nettype none

module wg_datapath #(
   parameter int TABLE_LEN   = 256,
   parameter int TABLE_COUNT = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wg_pkg::req_type    req_data,
   input  wire wg_pkg::cmd_type    cmd,
   output wg_pkg::status_type      st,
   output wg_pkg::rsp_type         rsp_data
);
   import wg_pkg::*;

   localparam int IDX_W       = $clog2(TABLE_LEN);
   localparam int ID_W        = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int HALF        = TABLE_LEN / 2;
   localparam int SAMPLE_SPAN = 1 << SAMPLE_INDEX_W;
   localparam logic [15:0] SAW_STEP = 16'(65535 / TABLE_LEN);
   localparam logic [15:0] TRI_STEP = 16'(131072 / TABLE_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_LEN - 1);

   // Item registers.
   logic [2:0]       func_ff;
   logic [ID_W-1:0]  id_ff;
   logic             id_ok_ff;
   logic             h_ok_ff;
   logic [IDX_W-1:0] h_ff;
   logic [7:0]       trim_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   // Walker and pipeline registers.
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] src_ff;
   logic [IDX_W-1:0] src_in;
   logic [IDX_W:0]   src_sum;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             s1_vld_ff;

   // Memory and read data.
   logic [15:0]        mem [TABLE_COUNT][TABLE_LEN];
   logic signed [15:0] tab_q_ff;
   logic signed [15:0] rom_q;
   logic [IDX_W-1:0]   rd_addr;

   // Write value arithmetic.
   logic [IDX_W-1:0]      mirror;
   logic [15:0]           ramp_step;
   logic [IDX_W-1:0]      ramp_pos;
   logic [IDX_W+15:0]     ramp_prod;
   logic [15:0]           ramp_val;
   logic signed [8:0]     trim_s;
   logic signed [24:0]    harm_prod;
   logic signed [16:0]    harm_add;
   logic signed [17:0]    harm_sum;
   logic signed [15:0]    harm_val;
   logic signed [15:0]    wr_data;

   // Result registers.
   logic signed [15:0] rsp_sample_ff;
   logic               rsp_read_ff;

   // Read index modulo the table length, as a constant lookup.
   logic [IDX_W-1:0] rd_mod [SAMPLE_SPAN];
   for (genvar g = 0; g < SAMPLE_SPAN; g++) begin : g_mod
      assign rd_mod[g] = IDX_W'(g % TABLE_LEN);
   end

   // Capture the item; a sine fill walks the reference at stride one.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_data.func;
         id_ff     <= ID_W'(req_data.wave_id);
         id_ok_ff  <= 32'(req_data.wave_id) < 32'(TABLE_COUNT);
         h_ok_ff   <= 32'(req_data.harmonic) < 32'(TABLE_LEN);
         h_ff      <= (req_data.func == FUNC_SINE) ? IDX_W'(1) : IDX_W'(req_data.harmonic);
         trim_ff   <= req_data.trim;
         rd_idx_ff <= rd_mod[req_data.sample_index];
      end
   end

   // Source index of the reference sine: (i*h) mod N, kept by addition.
   assign src_sum = (IDX_W + 1)'(src_ff) + (IDX_W + 1)'(h_ff);
   assign src_in  = (src_sum >= (IDX_W + 1)'(TABLE_LEN)) ?
                    IDX_W'(src_sum - (IDX_W + 1)'(TABLE_LEN)) : IDX_W'(src_sum);

   // Entry counters.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= '0;
         src_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         src_ff <= src_in;
      end
   end

   // The write stage follows the read stage in the cycle after it.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         s1_idx_ff <= idx_ff;
      end
   end

   // Reference sine lookup.
   wg_sine_rom #(
      .TABLE_LEN (TABLE_LEN)
   ) u_rom (
      .clock      (clock),
      .rd_en      (cmd.step),
      .rd_addr    (src_ff),
      .rd_data_ff (rom_q)
   );

   // Table memory: one write and one read address per cycle.
   assign rd_addr = cmd.read ? rd_idx_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         mem[id_ff][s1_idx_ff] <= wr_data;
      end
      if (cmd.step || cmd.read) begin
         tab_q_ff <= mem[id_ff][rd_addr];
      end
   end

   // Saw and triangle ramps share one multiplier.
   always_comb begin
      mirror    = LAST_IDX - s1_idx_ff;
      ramp_step = TRI_STEP;
      ramp_pos  = (s1_idx_ff < mirror) ? s1_idx_ff : mirror;
      if (func_ff == FUNC_SAW) begin
         ramp_step = SAW_STEP;
         ramp_pos  = s1_idx_ff;
      end
      ramp_prod = (IDX_W + 16)'(ramp_step) * (IDX_W + 16)'(ramp_pos);
      ramp_val  = RAMP_START + ramp_prod[15:0];
   end

   // Harmonic term, floored by the arithmetic shift, then saturated.
   always_comb begin
      trim_s    = $signed({1'b0, trim_ff});
      harm_prod = 25'(rom_q) * 25'(trim_s);
      harm_add  = 17'(harm_prod >>> 8);
      harm_sum  = 18'(tab_q_ff) + 18'(harm_add);
      if (harm_sum > 18'(SAMPLE_MAX)) begin
         harm_val = SAMPLE_MAX;
      end else if (harm_sum < 18'(SAMPLE_MIN)) begin
         harm_val = SAMPLE_MIN;
      end else begin
         harm_val = 16'(harm_sum);
      end
   end

   // Value written to the entry in the write stage.
   always_comb begin
      unique case (func_ff)
         FUNC_SINE:     wr_data = rom_q;
         FUNC_SQUARE:   wr_data = (s1_idx_ff < IDX_W'(HALF)) ? SAMPLE_MAX : SAMPLE_MIN;
         FUNC_SAW:      wr_data = $signed(ramp_val);
         FUNC_TRIANGLE: wr_data = $signed(ramp_val);
         FUNC_ADD:      wr_data = harm_val;
         default:       wr_data = '0;
      endcase
   end

   // Status toward the controller.
   always_comb begin
      st.read = id_ok_ff && (func_ff == FUNC_READ);
      st.walk = id_ok_ff && ((func_ff == FUNC_SINE) || (func_ff == FUNC_SQUARE) ||
                             (func_ff == FUNC_SAW) || (func_ff == FUNC_TRIANGLE) ||
                             (func_ff == FUNC_CLEAR) ||
                             ((func_ff == FUNC_ADD) && h_ok_ff));
      st.last = (idx_ff == LAST_IDX);
   end

   // Result register; only a read item carries data.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_sample_ff <= st.read ? tab_q_ff : '0;
         rsp_read_ff   <= st.read;
      end
   end

   assign rsp_data.sample  = rsp_sample_ff;
   assign rsp_data.is_read = rsp_read_ff;

endmodule

`default_nettype wire

// ===== src/wg_ctrl.sv =====
// Controller state machine for the wave table generator.
`default_nettype none

module wg_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output wg_pkg::cmd_type         cmd,
   input  wire wg_pkg::status_type st
);
   import wg_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_RUN    = 5'b00100,
      ST_READ   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (st.walk) begin
               state_in = ST_RUN;
            end else if (st.read) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (st.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Hand the result over once the output slot is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the wave table generator with a built-in table predictor.
`timescale 1ns / 100ps

module tb;
   import wg_pkg::*;

   localparam int TABLE_LEN      = DEF_TABLE_LEN;
   localparam int TABLE_COUNT    = DEF_TABLE_COUNT;
   localparam int RANDOM_ITEMS   = 600;
   localparam int HOLDOFF_CYCLES = 2000;
   localparam int IDLE_PERCENT   = 36;
   localparam int REPORT_LIMIT   = 10;

   // Function code with no meaning; the block must ignore it.
   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   wavetable_generator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Predicted contents of the sine ROM and of every wave table.
   logic signed [15:0] sine_ref [TABLE_LEN];
   logic signed [15:0] wave_mem [TABLE_COUNT][TABLE_LEN];

   // Items waiting to be offered and results waiting to be seen.
   req_type pending_cmds[$];
   rsp_type expected_samples[$];

   // Tables that the stimulus has already filled, tracked in queue order.
   bit filled_so_far [TABLE_COUNT];

   logic req_accepted = 1'b0;
   int   items_taken  = 0;
   int   fail_count   = 0;
   int   holdoff_left = 0;
   bit   holdoff_done = 1'b0;
   logic calm;

   // Both sides run without idling over one stretch of items.
   assign calm = (items_taken >= 150) && (items_taken < 260);

   always #5 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Taylor series of sin (odd) or cos (even) in unsigned Q2.30, clamped to [0, 1].
   function automatic longint series_q30(longint unsigned x, bit odd);
      longint unsigned x2, term, n;
      longint sum;
      x2   = (x * x) >> 30;
      term = odd ? x : ONE_Q30;
      sum  = signed'(term);
      n    = odd ? 2 : 1;
      for (int k = 0; k < SERIES_TERMS; k++) begin
         term = ((term * x2) >> 30) / (n * (n + 1));
         if (k % 2 == 1) begin
            sum += signed'(term);
         end else begin
            sum -= signed'(term);
         end
         n += 2;
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > signed'(ONE_Q30)) begin
         sum = signed'(ONE_Q30);
      end
      return sum;
   endfunction

   // Build the reference sine, one quadrant fold per entry.
   function automatic void build_sine_ref();
      longint unsigned a, q, r, x;
      longint v, m;
      for (int i = 0; i < TABLE_LEN; i++) begin
         a = 4 * i;
         q = a / TABLE_LEN;
         r = a % TABLE_LEN;
         x = (r * PIHALF_Q30) / TABLE_LEN;
         v = series_q30(x, q[0] == 1'b0);
         m = signed'((unsigned'(v) * 64'd32767) >> 30);
         if (m > 32767) begin
            m = 32767;
         end
         sine_ref[i] = 16'((q >= 2) ? -m : m);
      end
   endfunction

   // Apply one accepted item to the predicted tables and return its result.
   function automatic rsp_type apply_item(req_type item);
      rsp_type     result;
      logic [15:0] ramp, ramp_step;
      int          prod, wide, src;
      result = '0;
      if (int'(item.wave_id) >= TABLE_COUNT) begin
         return result;
      end
      case (item.func)
         FUNC_SINE: begin
            for (int i = 0; i < TABLE_LEN; i++) wave_mem[item.wave_id][i] = sine_ref[i];
         end
         FUNC_SQUARE: begin
            for (int i = 0; i < TABLE_LEN; i++) begin
               wave_mem[item.wave_id][i] = (i < TABLE_LEN / 2) ? SAMPLE_MAX : SAMPLE_MIN;
            end
         end
         FUNC_SAW: begin
            ramp_step = 16'(65535 / TABLE_LEN);
            ramp      = RAMP_START;
            for (int i = 0; i < TABLE_LEN; i++) begin
               wave_mem[item.wave_id][i] = ramp;
               ramp += ramp_step;
            end
         end
         FUNC_TRIANGLE: begin
            // Rising half mirrored from the end; an odd length gets a middle peak.
            ramp_step = 16'(131072 / TABLE_LEN);
            ramp      = RAMP_START;
            for (int i = 0; i < TABLE_LEN / 2; i++) begin
               wave_mem[item.wave_id][i]                 = ramp;
               wave_mem[item.wave_id][TABLE_LEN - 1 - i] = ramp;
               ramp += ramp_step;
            end
            if (TABLE_LEN % 2 == 1) begin
               wave_mem[item.wave_id][TABLE_LEN / 2] = ramp;
            end
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < TABLE_LEN; i++) wave_mem[item.wave_id][i] = '0;
         end
         FUNC_ADD: begin
            // A harmonic at or above the table length leaves the table alone.
            if (item.harmonic < TABLE_LEN) begin
               src = 0;
               for (int i = 0; i < TABLE_LEN; i++) begin
                  prod = int'(sine_ref[src]) * int'(item.trim);
                  wide = int'(wave_mem[item.wave_id][i]) + (prod >>> 8);
                  if (wide > 32767) begin
                     wide = 32767;
                  end
                  if (wide < -32768) begin
                     wide = -32768;
                  end
                  wave_mem[item.wave_id][i] = 16'(wide);
                  src += item.harmonic;
                  if (src >= TABLE_LEN) begin
                     src -= TABLE_LEN;
                  end
               end
            end
         end
         FUNC_READ: begin
            result.sample  = wave_mem[item.wave_id][item.sample_index % TABLE_LEN];
            result.is_read = 1'b1;
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   // Queue one item and note which tables it fills.
   task automatic queue_item(input logic [2:0] f, input logic [2:0] id, input logic [8:0] h,
                             input logic [7:0] tr, input logic [7:0] idx);
      req_type item;
      item.func         = f;
      item.wave_id      = id;
      item.harmonic     = h;
      item.trim         = tr;
      item.sample_index = idx;
      pending_cmds.push_back(item);
      if (f == FUNC_SINE || f == FUNC_SQUARE || f == FUNC_SAW || f == FUNC_TRIANGLE ||
          f == FUNC_CLEAR) begin
         filled_so_far[id] = 1'b1;
      end
   endtask

   // Record accepted items, predict their results and check every result.
   always @(posedge clock) begin : watch_ports
      rsp_type want;
      req_accepted = req_valid && !req_stall;
      if (!reset && req_accepted) begin
         expected_samples.push_back(apply_item(req_data));
         items_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("Unexpected result: sample %0d is_read %0b",
                        rsp_data.sample, rsp_data.is_read);
            end
         end else begin
            want = expected_samples.pop_front();
            if (rsp_data.sample !== want.sample || rsp_data.is_read !== want.is_read) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("Mismatch: sample %0d (expected %0d), is_read %0b (expected %0b)",
                           rsp_data.sample, want.sample, rsp_data.is_read, want.is_read);
               end
            end
         end
      end
   end

   // Offer the next item once the current one is taken, idling at random.
   always @(negedge clock) begin : drive_req
      req_type next_item;
      if (!reset && !(req_valid && !req_accepted)) begin
         if (pending_cmds.size() != 0 &&
             (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            next_item = pending_cmds.pop_front();
            req_data  <= next_item;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result side at random, with one long hold-off mid-run.
   always @(negedge clock) begin : drive_stall
      if (holdoff_left > 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && items_taken >= 300) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      logic [2:0] fill_codes [5];
      logic [2:0] f, id;
      logic [8:0] h;
      logic [7:0] tr, idx;
      int         sel, total_items;
      fill_codes = '{FUNC_SINE, FUNC_SQUARE, FUNC_SAW, FUNC_TRIANGLE, FUNC_CLEAR};
      build_sine_ref();

      // Every kind of fill, the unused code, and reads at the table edges.
      queue_item(FUNC_SINE, 0, 0, 0, 0);
      queue_item(FUNC_SQUARE, 1, 0, 0, 0);
      queue_item(FUNC_SAW, 2, 0, 0, 0);
      queue_item(FUNC_TRIANGLE, 3, 0, 0, 0);
      queue_item(FUNC_CLEAR, 4, 0, 0, 0);
      queue_item(FUNC_UNUSED, 5, 9'h1FF, 8'hFF, 8'hFF);
      queue_item(FUNC_READ, 0, 0, 0, 0);
      queue_item(FUNC_READ, 0, 0, 0, 64);
      queue_item(FUNC_READ, 0, 0, 0, 255);
      queue_item(FUNC_READ, 1, 0, 0, 127);
      queue_item(FUNC_READ, 1, 0, 0, 128);
      queue_item(FUNC_READ, 2, 0, 0, 255);
      queue_item(FUNC_READ, 3, 0, 0, 128);
      queue_item(FUNC_READ, 4, 0, 0, 200);
      // Harmonic adds: saturating, zero harmonic, too large (twice), largest valid with a tiny trim.
      queue_item(FUNC_ADD, 0, 1, 255, 0);
      queue_item(FUNC_ADD, 1, 0, 255, 0);
      queue_item(FUNC_ADD, 2, 256, 255, 0);
      queue_item(FUNC_ADD, 3, 511, 128, 0);
      queue_item(FUNC_ADD, 4, 255, 1, 0);
      queue_item(FUNC_ADD, 1, 3, 255, 0);
      queue_item(FUNC_READ, 0, 0, 0, 64);
      queue_item(FUNC_READ, 1, 0, 0, 1);
      queue_item(FUNC_READ, 4, 0, 0, 191);
      queue_item(FUNC_READ, 2, 0, 0, 17);

      // Random part: mostly reads and adds on filled tables, refilled now and then.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sel = $urandom_range(0, 99);
         id  = 3'($urandom);
         h   = 9'($urandom);
         tr  = 8'($urandom);
         idx = 8'($urandom);
         if (sel < 55) begin
            f = FUNC_READ;
         end else if (sel < 72) begin
            f = FUNC_ADD;
            if ($urandom_range(0, 3) != 0) begin
               h = 9'($urandom_range(0, TABLE_LEN - 1));
            end
         end else if (sel < 95) begin
            f = fill_codes[$urandom_range(0, 4)];
         end else begin
            f = FUNC_UNUSED;
         end
         // Never touch the contents of a table that was not filled yet.
         if ((f == FUNC_READ || f == FUNC_ADD) && !filled_so_far[id]) begin
            f = fill_codes[$urandom_range(0, 4)];
         end
         queue_item(f, id, h, tr, idx);
      end
      total_items = pending_cmds.size();

      // Wait until every item is taken and every predicted result has come back.
      while (items_taken < total_items || expected_samples.size() != 0) begin
         @(negedge clock);
      end
      repeat (TABLE_LEN + 8) @(negedge clock);

      if (expected_samples.size() != 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("Missing results: %0d still expected", expected_samples.size());
         end
      end
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
src/wg_pkg.sv
src/wg_sine_rom.sv
src/wg_datapath.sv
src/wg_ctrl.sv
src/wavetable_generator_unit.sv
tb/tb.sv
